FILE: rtl/pike_vm_regex_matcher_macros.svh
// Assertion macros shared by the regex matcher RTL.
`ifndef PIKE_VM_REGEX_MATCHER_MACROS_SVH
`define PIKE_VM_REGEX_MATCHER_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define PVM_CHECK(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// A condition that, once seen, must be followed by another in the next cycle.
`define PVM_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/pvm_pkg.sv
// Shared types and codes of the regex matcher.
`timescale 1ns / 1ps
package pvm_pkg;

  // Request types of an input item.
  localparam logic [1:0] REQ_PROG = 2'd0;
  localparam logic [1:0] REQ_CHAR = 2'd1;
  localparam logic [1:0] REQ_EOT  = 2'd2;

  // Instruction opcodes.
  localparam logic [2:0] OP_ANY   = 3'd0;
  localparam logic [2:0] OP_CHAR  = 3'd1;
  localparam logic [2:0] OP_MATCH = 3'd2;
  localparam logic [2:0] OP_SPLIT = 3'd3;
  localparam logic [2:0] OP_JUMP  = 3'd4;
  localparam logic [2:0] OP_OPEN  = 3'd5;
  localparam logic [2:0] OP_CLOSE = 3'd6;

  // One program word.
  typedef struct packed {
    logic [2:0] op;
    logic [7:0] ch;
    logic [5:0] x;
    logic [5:0] y;
  } word_t;

  // Status of the bracket pairing scan.
  typedef struct packed {
    logic done;
    logic bad;
  } pair_sts_t;

  // Group lookup hits.
  typedef struct packed {
    logic open_hit;
    logic close_hit;
  } look_t;

  // Bracket scanner states.
  typedef enum logic [2:0] {
    P_IDLE,
    P_RD,
    P_EX,
    P_POP,
    P_DONE
  } pstate_t;

  // Main sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_PAIR,
    S_SS_FIN,
    S_CL_CHK,
    S_CL_POP,
    S_CL_EX,
    S_CH_INIT,
    S_CH_RD,
    S_CH_LW,
    S_CH_EX,
    S_CH_FIN,
    S_EO_RD,
    S_EO_LW,
    S_EO_EX,
    S_OUT
  } state_t;

endpackage

FILE: rtl/pvm_pair.sv
// Bracket pairing scanner and capture group lookup.
`timescale 1ns / 1ps
module pvm_pair import pvm_pkg::*; #(
  parameter int PROG_DEPTH = 64,
  parameter int MAX_GROUPS = 8
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 scan_start,
  input  logic [$clog2(PROG_DEPTH+1)-1:0]      prog_len,
  output logic [$clog2(PROG_DEPTH)-1:0]        rd_addr,
  input  logic [2:0]                           rd_op,
  input  logic [$clog2(PROG_DEPTH)-1:0]        look_pc,
  output look_t                                look,
  output logic [((MAX_GROUPS>1)?$clog2(MAX_GROUPS):1)-1:0] open_g,
  output logic [((MAX_GROUPS>1)?$clog2(MAX_GROUPS):1)-1:0] close_g,
  output logic [$clog2(MAX_GROUPS+1)-1:0]      pair_count,
  output pair_sts_t                            sts
);

  localparam int AW = $clog2(PROG_DEPTH);
  localparam int LW = $clog2(PROG_DEPTH + 1);
  localparam int GW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int CW = $clog2(MAX_GROUPS + 1);
  localparam int NW = $clog2(MAX_GROUPS + 2);

  pstate_t        pst_r, pst_nxt;
  logic [AW-1:0]  i_r;
  logic [LW-1:0]  rs_r;
  logic [AW-1:0]  top_r;
  logic [NW-1:0]  n_r;
  logic           bad_r;
  logic [AW-1:0]  stk [PROG_DEPTH];
  logic [AW-1:0]  stk_q;
  logic [AW-1:0]  pl_r [MAX_GROUPS];
  logic [AW-1:0]  pr_r [MAX_GROUPS];

  logic ex_close, ex_open_ok, ex_open_bad, more;

  assign ex_close    = (rd_op == OP_CLOSE);
  assign ex_open_ok  = (rd_op == OP_OPEN) && (rs_r != '0);
  assign ex_open_bad = (rd_op == OP_OPEN) && (rs_r == '0);
  assign more        = (i_r != '0);
  assign rd_addr     = i_r;

  // Number of pairs kept, limited to the group count.
  assign pair_count = (32'(n_r) > MAX_GROUPS) ? CW'(MAX_GROUPS) : CW'(n_r);

  // Scan sequencing: top-down walk over the program words.
  always_comb begin
    pst_nxt = pst_r;
    sts     = '0;
    case (pst_r)
      P_IDLE: begin
        if (scan_start) begin
          pst_nxt = (prog_len == '0) ? P_DONE : P_RD;
        end
      end
      P_RD: begin
        pst_nxt = P_EX;
      end
      P_EX: begin
        if (ex_open_bad) begin
          pst_nxt = P_DONE;
        end else if (ex_open_ok && (rs_r >= LW'(2))) begin
          pst_nxt = P_POP;
        end else begin
          pst_nxt = more ? P_RD : P_DONE;
        end
      end
      P_POP: begin
        pst_nxt = more ? P_RD : P_DONE;
      end
      P_DONE: begin
        sts.done = 1'b1;
        sts.bad  = bad_r || (rs_r != '0) || (32'(n_r) > MAX_GROUPS);
        pst_nxt  = P_IDLE;
      end
      default: pst_nxt = P_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pst_r <= P_IDLE;
      rs_r  <= '0;
      n_r   <= '0;
      bad_r <= 1'b0;
    end else begin
      pst_r <= pst_nxt;
      case (pst_r)
        P_IDLE: begin
          if (scan_start) begin
            rs_r  <= '0;
            n_r   <= '0;
            bad_r <= 1'b0;
            i_r   <= AW'(prog_len - LW'(1));
          end
        end
        P_EX: begin
          if (ex_close) begin
            rs_r  <= rs_r + LW'(1);
            top_r <= i_r;
          end else if (ex_open_ok) begin
            rs_r <= rs_r - LW'(1);
            if (32'(n_r) <= MAX_GROUPS) begin
              n_r <= n_r + NW'(1);
            end
          end else if (ex_open_bad) begin
            bad_r <= 1'b1;
          end
          if (pst_nxt == P_RD) begin
            i_r <= i_r - AW'(1);
          end
        end
        P_POP: begin
          top_r <= stk_q;
          if (pst_nxt == P_RD) begin
            i_r <= i_r - AW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // Stack of unpaired close brackets below the top register.
  always_ff @(posedge clk) begin
    if (pst_r == P_EX && ex_close && rs_r != '0) begin
      stk[AW'(rs_r - LW'(1))] <= top_r;
    end
    stk_q <= stk[AW'(rs_r - LW'(2))];
  end

  // Pair list: newest pair enters at slot zero, so slot order follows open order.
  always_ff @(posedge clk) begin
    if (pst_r == P_EX && ex_open_ok) begin
      pl_r[0] <= i_r;
      pr_r[0] <= top_r;
      for (int k = 1; k < MAX_GROUPS; k++) begin
        pl_r[k] <= pl_r[k-1];
        pr_r[k] <= pr_r[k-1];
      end
    end
  end

  // Group lookup by bracket position; the lowest group wins.
  always_comb begin
    look    = '0;
    open_g  = '0;
    close_g = '0;
    for (int k = MAX_GROUPS - 1; k >= 0; k--) begin
      if (32'(k) < 32'(pair_count)) begin
        if (pl_r[k] == look_pc) begin
          look.open_hit = 1'b1;
          open_g        = GW'(k);
        end
        if (pr_r[k] == look_pc) begin
          look.close_hit = 1'b1;
          close_g        = GW'(k);
        end
      end
    end
  end

endmodule

FILE: rtl/pike_vm_regex_matcher.sv
// Top level of the Pike-style regex matcher with capture groups.
`timescale 1ns / 1ps
// Program words are written one per item. Text characters then arrive one per
// item; the first character or end-of-text of a session first runs a bracket
// pairing scan that reads and examines each program word, with an extra pop step
// for each open bracket that uncovers a nested close bracket.
// A character reads, loads and examines each live thread in turn and follows the
// epsilon closure of every thread that takes it, with a stack pop per pending
// split branch; all of it runs on one sequencer sharing a single program memory
// read port, so the work grows with the thread and closure counts. End of text
// scans the live threads for a match and then emits one result per cycle, one
// per group (at most eight, or a single one with no groups), on out_strobe for
// exactly one cycle each; the receiver cannot hold results off. busy is high
// while an item works.
module pike_vm_regex_matcher import pvm_pkg::*; #(
  parameter int PROG_DEPTH = 64,
  parameter int MAX_GROUPS = 8,
  parameter int INDEX_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_req_type,
  input  logic [5:0]  in_prog_addr,
  input  logic [2:0]  in_prog_op,
  input  logic [7:0]  in_prog_char,
  input  logic [5:0]  in_prog_x,
  input  logic [5:0]  in_prog_y,
  input  logic [7:0]  in_text_char,
  output logic        out_strobe,
  output logic        out_matched,
  output logic [2:0]  out_group_index,
  output logic        out_start_valid,
  output logic [15:0] out_group_start,
  output logic        out_end_valid,
  output logic [15:0] out_group_end,
  output logic        out_error,
  output logic        out_last
);

  `include "pike_vm_regex_matcher_macros.svh"

  localparam int AW  = $clog2(PROG_DEPTH);
  localparam int LW  = $clog2(PROG_DEPTH + 1);
  localparam int PCW = (LW > 6) ? LW : 6;
  localparam int GW  = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int CW  = $clog2(MAX_GROUPS + 1);

  typedef struct packed {
    logic [MAX_GROUPS-1:0]                 sv;
    logic [MAX_GROUPS-1:0][INDEX_BITS-1:0] s;
    logic [MAX_GROUPS-1:0]                 ev;
    logic [MAX_GROUPS-1:0][INDEX_BITS-1:0] e;
  } caps_t;

  typedef struct packed {
    logic [PCW-1:0] pc;
    caps_t          c;
  } thr_t;

  state_t                state_r, state_nxt, ret_r;
  logic                  active_r, err_r, found_r;
  logic [INDEX_BITS-1:0] pos_r, posc_r, nxtpos_r;
  logic [LW-1:0]         prog_len_r, cur_cnt_r, dcnt_r, i_r, cs_r;
  logic                  cur_sel_r, dest_sel_r, cont_r;
  logic [1:0]            req_r;
  logic [7:0]            tc_r;
  thr_t                  t_r;
  caps_t                 best_r;
  logic [PROG_DEPTH-1:0] seen_r;
  logic [2:0]            k_r;

  logic                  out_strobe_r, out_matched_r, out_sv_r, out_ev_r;
  logic                  out_error_r, out_last_r;
  logic [2:0]            out_gi_r;
  logic [15:0]           out_gs_r, out_ge_r;

  // Memories.
  word_t         prog_mem [PROG_DEPTH];
  word_t         prog_q;
  logic [AW-1:0] prog_ra;
  thr_t          list_a [PROG_DEPTH];
  thr_t          list_b [PROG_DEPTH];
  thr_t          la_q, lb_q, list_rd;
  thr_t          stk [PROG_DEPTH];
  thr_t          stk_q;

  // Pairing unit hookup.
  logic            scan_start;
  logic [AW-1:0]   pair_addr;
  look_t           look;
  logic [GW-1:0]   open_g, close_g;
  logic [CW-1:0]   pair_cnt;
  pair_sts_t       psts;

  logic accept, pc_ok, stk_room, stk_room2, take, dest_room, last_k;
  logic cap_set, wr_dest, wr_stk;
  logic [3:0] n_res;
  logic [GW-1:0] kidx;
  thr_t split_y;

  assign accept     = start && !busy;
  assign busy       = (state_r != S_IDLE);
  assign scan_start = accept && !active_r &&
                      (in_req_type == REQ_CHAR || in_req_type == REQ_EOT);

  pvm_pair #(
    .PROG_DEPTH(PROG_DEPTH),
    .MAX_GROUPS(MAX_GROUPS)
  ) u_pair (
    .clk       (clk),
    .rst_n     (rst_n),
    .scan_start(scan_start),
    .prog_len  (prog_len_r),
    .rd_addr   (pair_addr),
    .rd_op     (prog_q.op),
    .look_pc   (t_r.pc[AW-1:0]),
    .look      (look),
    .open_g    (open_g),
    .close_g   (close_g),
    .pair_count(pair_cnt),
    .sts       (psts)
  );

  // Shared decision logic of the sequencer.
  assign list_rd   = cur_sel_r ? lb_q : la_q;
  assign pc_ok     = (t_r.pc < PCW'(prog_len_r)) && !seen_r[t_r.pc[AW-1:0]];
  assign stk_room  = (32'(cs_r) < PROG_DEPTH);
  assign stk_room2 = (32'(cs_r) + 1 < PROG_DEPTH);
  assign dest_room = (32'(dcnt_r) < PROG_DEPTH);
  assign take      = (prog_q.op == OP_ANY) ||
                     (prog_q.op == OP_CHAR && prog_q.ch == tc_r);
  assign cap_set   = look.open_hit &&
                     (!t_r.c.sv[open_g] ||
                      (t_r.c.ev[open_g] && posc_r > t_r.c.e[open_g]));
  assign wr_dest   = (state_r == S_CL_EX) && dest_room &&
                     !(prog_q.op == OP_JUMP || prog_q.op == OP_SPLIT ||
                       prog_q.op == OP_OPEN || prog_q.op == OP_CLOSE);
  assign wr_stk    = (state_r == S_CL_EX) && (prog_q.op == OP_SPLIT) && stk_room;

  always_comb begin
    split_y    = t_r;
    split_y.pc = PCW'(prog_q.y);
  end

  // Result count and position of the current result.
  assign n_res  = (pair_cnt == '0) ? 4'd1 :
                  (32'(pair_cnt) > 8) ? 4'd8 : 4'(pair_cnt);
  assign last_k = ({1'b0, k_r} + 4'd1 == n_res);
  assign kidx   = GW'(k_r);

  // Program memory read address by phase.
  always_comb begin
    case (state_r)
      S_CL_CHK: prog_ra = t_r.pc[AW-1:0];
      S_CH_LW:  prog_ra = list_rd.pc[AW-1:0];
      S_EO_LW:  prog_ra = list_rd.pc[AW-1:0];
      default:  prog_ra = pair_addr;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept && in_req_type == REQ_PROG && 32'(in_prog_addr) < PROG_DEPTH) begin
      prog_mem[AW'(in_prog_addr)] <= '{op: in_prog_op, ch: in_prog_char,
                                       x: in_prog_x, y: in_prog_y};
    end
    prog_q <= prog_mem[prog_ra];
  end

  // Thread lists, used in turn as current and next list.
  always_ff @(posedge clk) begin
    if (wr_dest && !dest_sel_r) begin
      list_a[dcnt_r[AW-1:0]] <= t_r;
    end
    if (wr_dest && dest_sel_r) begin
      list_b[dcnt_r[AW-1:0]] <= t_r;
    end
    la_q <= list_a[i_r[AW-1:0]];
    lb_q <= list_b[i_r[AW-1:0]];
  end

  // Closure stack; the thread being followed stays in t_r.
  always_ff @(posedge clk) begin
    if (wr_stk) begin
      stk[cs_r[AW-1:0]] <= split_y;
    end
    stk_q <= stk[AW'(cs_r - LW'(1))];
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept && (in_req_type == REQ_CHAR || in_req_type == REQ_EOT)) begin
          if (!active_r) begin
            state_nxt = S_PAIR;
          end else begin
            state_nxt = (in_req_type == REQ_CHAR) ? S_CH_INIT : S_EO_RD;
          end
        end
      end
      S_PAIR:   if (psts.done) state_nxt = S_CL_CHK;
      S_SS_FIN: state_nxt = (req_r == REQ_CHAR) ? S_CH_INIT : S_EO_RD;
      S_CL_CHK: begin
        if (cont_r) begin
          if (pc_ok) state_nxt = S_CL_EX;
        end else if (cs_r == '0) begin
          state_nxt = ret_r;
        end else begin
          state_nxt = S_CL_POP;
        end
      end
      S_CL_POP:  state_nxt = S_CL_CHK;
      S_CL_EX:   state_nxt = S_CL_CHK;
      S_CH_INIT: state_nxt = S_CH_RD;
      S_CH_RD:   state_nxt = (i_r == cur_cnt_r) ? S_CH_FIN : S_CH_LW;
      S_CH_LW:   state_nxt = S_CH_EX;
      S_CH_EX: begin
        if (take) begin
          state_nxt = S_CL_CHK;
        end else if (prog_q.op == OP_MATCH) begin
          state_nxt = S_CH_FIN;
        end else begin
          state_nxt = S_CH_RD;
        end
      end
      S_CH_FIN: state_nxt = S_IDLE;
      S_EO_RD:  state_nxt = (i_r == cur_cnt_r) ? S_OUT : S_EO_LW;
      S_EO_LW:  state_nxt = S_EO_EX;
      S_EO_EX:  state_nxt = (prog_q.op == OP_MATCH) ? S_OUT : S_EO_RD;
      S_OUT:    if (last_k) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
    end else begin
      state_r  <= state_nxt;
    end
  end

  // Sequencer datapath.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ret_r        <= S_IDLE;
      active_r     <= 1'b0;
      err_r        <= 1'b0;
      found_r      <= 1'b0;
      pos_r        <= '0;
      prog_len_r   <= '0;
      cur_cnt_r    <= '0;
      dcnt_r       <= '0;
      i_r          <= '0;
      cs_r         <= '0;
      cur_sel_r    <= 1'b0;
      dest_sel_r   <= 1'b0;
      cont_r       <= 1'b0;
      seen_r       <= '0;
      best_r.sv    <= '0;
      best_r.ev    <= '0;
      k_r          <= '0;
      out_strobe_r <= 1'b0;
      out_last_r   <= 1'b0;
    end else begin
      out_strobe_r <= 1'b0;
      out_last_r   <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            req_r <= in_req_type;
            tc_r  <= in_text_char;
            i_r   <= '0;
            if (in_req_type == REQ_PROG) begin
              if (32'(in_prog_addr) < PROG_DEPTH &&
                  32'(in_prog_addr) >= 32'(prog_len_r)) begin
                prog_len_r <= LW'(32'(in_prog_addr) + 1);
              end
            end else if (in_req_type == REQ_CHAR || in_req_type == REQ_EOT) begin
              if (!active_r) begin
                active_r  <= 1'b1;
                err_r     <= 1'b0;
                found_r   <= 1'b0;
                best_r.sv <= '0;
                best_r.ev <= '0;
                pos_r     <= '0;
                cur_cnt_r <= '0;
              end
            end
          end
        end
        S_PAIR: begin
          if (psts.done) begin
            if (psts.bad) err_r <= 1'b1;
            seen_r     <= '0;
            t_r        <= '0;
            cont_r     <= 1'b1;
            cs_r       <= '0;
            dcnt_r     <= '0;
            dest_sel_r <= cur_sel_r;
            posc_r     <= '0;
            ret_r      <= S_SS_FIN;
          end
        end
        S_SS_FIN: begin
          cur_cnt_r <= dcnt_r;
          i_r       <= '0;
        end
        S_CL_CHK: begin
          if (cont_r) begin
            if (pc_ok) begin
              seen_r[t_r.pc[AW-1:0]] <= 1'b1;
            end else begin
              cont_r <= 1'b0;
            end
          end else if (cs_r != '0) begin
            cs_r <= cs_r - LW'(1);
          end
        end
        S_CL_POP: begin
          t_r    <= stk_q;
          cont_r <= 1'b1;
        end
        S_CL_EX: begin
          case (prog_q.op)
            OP_JUMP: begin
              t_r.pc <= PCW'(prog_q.x);
              cont_r <= stk_room;
              if (!stk_room) err_r <= 1'b1;
            end
            OP_SPLIT: begin
              if (stk_room) begin
                cs_r   <= cs_r + LW'(1);
                t_r.pc <= PCW'(prog_q.x);
                cont_r <= stk_room2;
                if (!stk_room2) err_r <= 1'b1;
              end else begin
                cont_r <= 1'b0;
                err_r  <= 1'b1;
              end
            end
            OP_OPEN: begin
              if (cap_set) begin
                t_r.c.sv[open_g] <= 1'b1;
                t_r.c.s[open_g]  <= posc_r;
              end
              t_r.pc <= t_r.pc + PCW'(1);
              cont_r <= stk_room;
              if (!stk_room) err_r <= 1'b1;
            end
            OP_CLOSE: begin
              if (look.close_hit) begin
                t_r.c.ev[close_g] <= 1'b1;
                t_r.c.e[close_g]  <= posc_r;
              end
              t_r.pc <= t_r.pc + PCW'(1);
              cont_r <= stk_room;
              if (!stk_room) err_r <= 1'b1;
            end
            default: begin
              if (dest_room) dcnt_r <= dcnt_r + LW'(1);
              cont_r <= 1'b0;
            end
          endcase
        end
        S_CH_INIT: begin
          if (&pos_r) begin
            err_r    <= 1'b1;
            nxtpos_r <= pos_r;
            posc_r   <= pos_r;
          end else begin
            nxtpos_r <= pos_r + INDEX_BITS'(1);
            posc_r   <= pos_r + INDEX_BITS'(1);
          end
          seen_r     <= '0;
          i_r        <= '0;
          dcnt_r     <= '0;
          dest_sel_r <= !cur_sel_r;
          ret_r      <= S_CH_RD;
        end
        S_CH_LW: t_r <= list_rd;
        S_CH_EX: begin
          if (take) begin
            t_r.pc <= t_r.pc + PCW'(1);
            cont_r <= 1'b1;
            cs_r   <= '0;
            i_r    <= i_r + LW'(1);
          end else if (prog_q.op == OP_MATCH) begin
            best_r  <= t_r.c;
            found_r <= 1'b1;
          end else begin
            i_r <= i_r + LW'(1);
          end
        end
        S_CH_FIN: begin
          cur_sel_r <= dest_sel_r;
          cur_cnt_r <= dcnt_r;
          pos_r     <= nxtpos_r;
        end
        S_EO_LW: t_r <= list_rd;
        S_EO_EX: begin
          if (prog_q.op == OP_MATCH) begin
            best_r  <= t_r.c;
            found_r <= 1'b1;
          end else begin
            i_r <= i_r + LW'(1);
          end
        end
        S_OUT: begin
          out_strobe_r  <= 1'b1;
          out_last_r    <= last_k;
          out_matched_r <= found_r;
          out_gi_r      <= k_r;
          out_error_r   <= err_r;
          out_sv_r      <= 1'b0;
          out_gs_r      <= '0;
          out_ev_r      <= 1'b0;
          out_ge_r      <= '0;
          if (found_r && 32'(k_r) < 32'(pair_cnt)) begin
            out_sv_r <= best_r.sv[kidx];
            out_ev_r <= best_r.ev[kidx];
            if (best_r.sv[kidx]) out_gs_r <= 16'(32'(best_r.s[kidx]));
            if (best_r.ev[kidx]) out_ge_r <= 16'(32'(best_r.e[kidx]));
          end
          if (last_k) begin
            k_r       <= '0;
            active_r  <= 1'b0;
            cur_cnt_r <= '0;
            pos_r     <= '0;
            found_r   <= 1'b0;
            err_r     <= 1'b0;
            best_r.sv <= '0;
            best_r.ev <= '0;
          end else begin
            k_r <= k_r + 3'd1;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_strobe      = out_strobe_r;
  assign out_matched     = out_matched_r;
  assign out_group_index = out_gi_r;
  assign out_start_valid = out_sv_r;
  assign out_group_start = out_gs_r;
  assign out_end_valid   = out_ev_r;
  assign out_group_end   = out_ge_r;
  assign out_error       = out_error_r;
  assign out_last        = out_last_r;

  // Checks on sequencing.
  `PVM_CHECK_NEXT(a_text_goes_busy,
    start && !busy && (in_req_type == REQ_CHAR || in_req_type == REQ_EOT), busy,
    "text item accepted without going busy")
  `PVM_CHECK_NEXT(a_emit_strobes, state_r == S_OUT, out_strobe,
    "result phase produced no strobe")
  `PVM_CHECK(a_last_has_strobe, !out_last || out_strobe,
    "last flag without a result")
  `PVM_CHECK(a_stack_bound, 32'(cs_r) <= PROG_DEPTH && 32'(dcnt_r) <= PROG_DEPTH,
    "closure stack or thread list count beyond depth")

endmodule

FILE: bench/regex_capture_checker.sv
// Capture checker for the regex matcher: predicts each end-of-text report and compares it.
`timescale 1ns / 1ps
module regex_capture_checker import pvm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  in_req_type,
  input  logic [5:0]  in_prog_addr,
  input  logic [2:0]  in_prog_op,
  input  logic [7:0]  in_prog_char,
  input  logic [5:0]  in_prog_x,
  input  logic [5:0]  in_prog_y,
  input  logic [7:0]  in_text_char,
  input  logic        out_strobe,
  input  logic        out_matched,
  input  logic [2:0]  out_group_index,
  input  logic        out_start_valid,
  input  logic [15:0] out_group_start,
  input  logic        out_end_valid,
  input  logic [15:0] out_group_end,
  input  logic        out_error,
  input  logic        out_last,
  output int          fail_count,
  output int          pending_count,
  output int          result_count,
  output int          match_count
);

  localparam int DEPTH  = 64;
  localparam int GROUPS = 8;
  localparam int RQ_DEPTH = 64;

  // Start and end slots of every group carried by one thread.
  typedef struct packed {
    logic [GROUPS-1:0]       sv;
    logic [GROUPS-1:0]       ev;
    logic [GROUPS-1:0][15:0] s;
    logic [GROUPS-1:0][15:0] e;
  } capture_set_t;

  typedef struct packed {
    logic [6:0]   pc;
    capture_set_t c;
  } thread_t;

  // One group report as it should appear on the result ports.
  typedef struct packed {
    logic        matched;
    logic [2:0]  gidx;
    logic        sv;
    logic [15:0] gs;
    logic        ev;
    logic [15:0] ge;
    logic        err;
    logic        last;
  } group_report_t;

  word_t         prog_mem [DEPTH];
  int            prog_len;
  int            pair_open [GROUPS];
  int            pair_close [GROUPS];
  int            n_pairs;
  thread_t       live [DEPTH];
  int            live_n;
  thread_t       born [DEPTH];
  int            born_n;
  thread_t       walk_stack [DEPTH];
  int            walk_sp;
  bit            visited [DEPTH];
  capture_set_t  best;
  logic [15:0]   text_pos;
  bit            found;
  bit            sticky_err;
  bit            in_session;
  group_report_t report_ring [RQ_DEPTH];
  int            rep_wr;
  int            rep_rd;

  assign pending_count = rep_wr - rep_rd;

  // Pair brackets from the top of the program down.
  function automatic void scan_brackets();
    int rstk [DEPTH];
    int tl [DEPTH];
    int tr [DEPTH];
    int rs;
    int n;
    bit bad;
    rs = 0;
    n = 0;
    bad = 0;
    for (int i = prog_len - 1; i >= 0; i--) begin
      if (prog_mem[i].op == OP_CLOSE) begin
        rstk[rs] = i;
        rs++;
      end else if (prog_mem[i].op == OP_OPEN) begin
        if (rs == 0) begin
          bad = 1;
          break;
        end
        tl[n] = i;
        rs--;
        tr[n] = rstk[rs];
        n++;
      end
    end
    if (rs != 0) bad = 1;
    n_pairs = n;
    if (n > GROUPS) begin
      n_pairs = GROUPS;
      bad = 1;
    end
    for (int k = 0; k < n_pairs; k++) begin
      pair_open[k] = tl[n - 1 - k];
      pair_close[k] = tr[n - 1 - k];
    end
    if (bad) sticky_err = 1;
  endfunction

  function automatic int group_of(int pc, bit close_side);
    for (int k = 0; k < n_pairs; k++) begin
      if ((close_side ? pair_close[k] : pair_open[k]) == pc) return k;
    end
    return GROUPS;
  endfunction

  function automatic void push_walk(logic [6:0] pc, capture_set_t c);
    if (walk_sp >= DEPTH) begin
      sticky_err = 1;
      return;
    end
    walk_stack[walk_sp].pc = pc;
    walk_stack[walk_sp].c = c;
    walk_sp++;
  endfunction

  // Follow the epsilon moves from one pc and add the threads that wait on text.
  function automatic void follow_epsilon(bit into_born, logic [6:0] pc0, capture_set_t c0,
                                         logic [15:0] p);
    thread_t t;
    word_t   w;
    int      g;
    walk_sp = 0;
    push_walk(pc0, c0);
    while (walk_sp > 0) begin
      walk_sp--;
      t = walk_stack[walk_sp];
      if (t.pc >= prog_len) continue;
      if (visited[t.pc]) continue;
      visited[t.pc] = 1;
      w = prog_mem[t.pc];
      case (w.op)
        OP_JUMP: begin
          push_walk({1'b0, w.x}, t.c);
        end
        OP_SPLIT: begin
          push_walk({1'b0, w.y}, t.c);
          push_walk({1'b0, w.x}, t.c);
        end
        OP_OPEN: begin
          g = group_of(t.pc, 0);
          if (g < GROUPS && (!t.c.sv[g] || (t.c.ev[g] && p > t.c.e[g]))) begin
            t.c.sv[g] = 1;
            t.c.s[g] = p;
          end
          push_walk(t.pc + 7'd1, t.c);
        end
        OP_CLOSE: begin
          g = group_of(t.pc, 1);
          if (g < GROUPS) begin
            t.c.ev[g] = 1;
            t.c.e[g] = p;
          end
          push_walk(t.pc + 7'd1, t.c);
        end
        default: begin
          if (into_born) begin
            if (born_n < DEPTH) born[born_n++] = t;
          end else begin
            if (live_n < DEPTH) live[live_n++] = t;
          end
        end
      endcase
    end
  endfunction

  function automatic void open_session();
    in_session = 1;
    sticky_err = 0;
    found = 0;
    best = '0;
    text_pos = '0;
    live_n = 0;
    born_n = 0;
    scan_brackets();
    foreach (visited[i]) visited[i] = 0;
    follow_epsilon(0, 7'd0, '0, 16'd0);
  endfunction

  // Advance the thread list over one text byte.
  function automatic void step_char(logic [7:0] ch);
    logic [15:0] np;
    word_t       w;
    if (text_pos == 16'hFFFF) begin
      np = 16'hFFFF;
      sticky_err = 1;
    end else begin
      np = text_pos + 16'd1;
    end
    born_n = 0;
    foreach (visited[i]) visited[i] = 0;
    for (int i = 0; i < live_n; i++) begin
      w = prog_mem[live[i].pc];
      if (w.op == OP_ANY || (w.op == OP_CHAR && w.ch == ch)) begin
        follow_epsilon(1, live[i].pc + 7'd1, live[i].c, np);
      end else if (w.op == OP_MATCH) begin
        best = live[i].c;
        found = 1;
        break;
      end
    end
    for (int i = 0; i < born_n; i++) live[i] = born[i];
    live_n = born_n;
    born_n = 0;
    text_pos = np;
  endfunction

  // End of text: queue one report per group (one if there are none) and close the session.
  function automatic void emit_captures();
    group_report_t r;
    int            n;
    for (int i = 0; i < live_n; i++) begin
      if (prog_mem[live[i].pc].op == OP_MATCH) begin
        best = live[i].c;
        found = 1;
        break;
      end
    end
    n = (n_pairs != 0) ? n_pairs : 1;
    for (int i = 0; i < n; i++) begin
      r.matched = found;
      r.gidx = i[2:0];
      r.sv = found && i < n_pairs && best.sv[i];
      r.gs = r.sv ? best.s[i] : 16'd0;
      r.ev = found && i < n_pairs && best.ev[i];
      r.ge = r.ev ? best.e[i] : 16'd0;
      r.err = sticky_err;
      r.last = (i + 1 == n);
      report_ring[rep_wr % RQ_DEPTH] = r;
      rep_wr++;
    end
    in_session = 0;
    live_n = 0;
    text_pos = '0;
    found = 0;
    sticky_err = 0;
    best = '0;
  endfunction

  function automatic void note_failure(string what, group_report_t want, group_report_t got);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%0t: %s", $realtime, what);
      $display("  expected m=%0b g=%0d sv=%0b s=%0d ev=%0b e=%0d err=%0b last=%0b",
               want.matched, want.gidx, want.sv, want.gs, want.ev, want.ge, want.err,
               want.last);
      $display("  actual   m=%0b g=%0d sv=%0b s=%0d ev=%0b e=%0d err=%0b last=%0b",
               got.matched, got.gidx, got.sv, got.gs, got.ev, got.ge, got.err, got.last);
    end
  endfunction

  initial begin
    fail_count = 0;
    result_count = 0;
    match_count = 0;
    prog_len = 0;
    n_pairs = 0;
    live_n = 0;
    in_session = 0;
    rep_wr = 0;
    rep_rd = 0;
  end

  // Compare results first, then fold in the item accepted at this edge.
  always @(posedge clk) begin
    group_report_t got;
    group_report_t want;
    word_t         w;
    if (rst_n) begin
      if (out_strobe) begin
        got = '{out_matched, out_group_index, out_start_valid, out_group_start,
                out_end_valid, out_group_end, out_error, out_last};
        result_count++;
        if (out_matched) match_count++;
        if (rep_wr == rep_rd) begin
          note_failure("result with no report pending", '0, got);
        end else begin
          want = report_ring[rep_rd % RQ_DEPTH];
          rep_rd++;
          if (got != want) note_failure("report mismatch", want, got);
        end
      end
      if (start && !busy) begin
        case (in_req_type)
          REQ_PROG: begin
            w.op = in_prog_op;
            w.ch = in_prog_char;
            w.x = in_prog_x;
            w.y = in_prog_y;
            prog_mem[in_prog_addr] = w;
            if (int'(in_prog_addr) + 1 > prog_len) prog_len = int'(in_prog_addr) + 1;
          end
          REQ_CHAR: begin
            if (!in_session) open_session();
            step_char(in_text_char);
          end
          REQ_EOT: begin
            if (!in_session) open_session();
            emit_captures();
          end
          default: ;
        endcase
      end
    end
  end

endmodule

FILE: bench/pike_vm_regex_matcher_tb.sv
// Testbench top of the regex matcher: builds programs and text sessions and gives the verdict.
`timescale 1ns / 1ps
module pike_vm_regex_matcher_tb import pvm_pkg::*;;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_req_type;
  logic [5:0]  in_prog_addr;
  logic [2:0]  in_prog_op;
  logic [7:0]  in_prog_char;
  logic [5:0]  in_prog_x;
  logic [5:0]  in_prog_y;
  logic [7:0]  in_text_char;
  logic        out_strobe;
  logic        out_matched;
  logic [2:0]  out_group_index;
  logic        out_start_valid;
  logic [15:0] out_group_start;
  logic        out_end_valid;
  logic [15:0] out_group_end;
  logic        out_error;
  logic        out_last;
  int          fail_count;
  int          pending_count;
  int          result_count;
  int          match_count;

  word_t prog_img [64];
  int    prog_n;
  int    top_addr;
  int    item_count;
  int    session_count;
  bit    calm;

  pike_vm_regex_matcher i_dut (.*);

  regex_capture_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #100ms;
    $display("== FAIL ==");
    $finish;
  end

  // Present one item and return at the edge that accepts it.
  task automatic send(logic [1:0] rt, logic [5:0] a, logic [2:0] op, logic [7:0] ch,
                      logic [5:0] x, logic [5:0] y, logic [7:0] tc);
    if (!calm && $urandom_range(99) < 22) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start <= 1'b1;
    in_req_type <= rt;
    in_prog_addr <= a;
    in_prog_op <= op;
    in_prog_char <= ch;
    in_prog_x <= x;
    in_prog_y <= y;
    in_text_char <= tc;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
    if (rt != 2'd3) item_count++;
    if (rt == REQ_PROG && int'(a) > top_addr) top_addr = int'(a);
  endtask

  task automatic send_char(logic [7:0] c);
    send(REQ_CHAR, 6'($urandom), 3'($urandom), 8'($urandom), 6'($urandom), 6'($urandom), c);
  endtask

  task automatic send_eot();
    send(REQ_EOT, 6'($urandom), 3'($urandom), 8'($urandom), 6'($urandom), 6'($urandom),
         8'($urandom));
    session_count++;
  endtask

  // Load the program image, starting at a random word and wrapping around.
  task automatic load_program();
    int first;
    int k;
    first = $urandom_range(prog_n - 1);
    for (int i = 0; i < prog_n; i++) begin
      k = (first + i) % prog_n;
      send(REQ_PROG, k[5:0], prog_img[k].op, prog_img[k].ch, prog_img[k].x, prog_img[k].y,
           8'($urandom));
    end
  endtask

  function automatic int emit(logic [2:0] op, logic [7:0] ch, int x, int y);
    if (prog_n >= 62) return -1;
    prog_img[prog_n] = '{op, ch, x[5:0], y[5:0]};
    prog_n++;
    return prog_n - 1;
  endfunction

  function automatic logic [7:0] pick_letter();
    if ($urandom_range(9) == 0) return 8'($urandom);
    return 8'h61 + 8'($urandom_range(2));
  endfunction

  // Compile a random regex-shaped fragment: literals, wildcards, groups, loops, choices.
  function automatic void gen_seq(int depth);
    int n;
    int s;
    int j;
    int d;
    n = $urandom_range(1, 3);
    for (int i = 0; i < n; i++) begin
      case ((depth > 0) ? $urandom_range(7) : $urandom_range(3))
        0, 1, 2: d = emit(OP_CHAR, pick_letter(), 0, 0);
        3: d = emit(OP_ANY, 8'($urandom), 0, 0);
        4: begin
          d = emit(OP_OPEN, 8'($urandom), 0, 0);
          gen_seq(depth - 1);
          d = emit(OP_CLOSE, 8'($urandom), 0, 0);
        end
        5, 6: begin
          // Greedy or lazy loop around one fragment.
          s = emit(OP_SPLIT, 8'($urandom), 0, 0);
          gen_seq(depth - 1);
          d = emit(OP_JUMP, 8'($urandom), s, 0);
          if (s >= 0) begin
            if ($urandom_range(1)) begin
              prog_img[s].x = 6'(s + 1);
              prog_img[s].y = 6'(prog_n);
            end else begin
              prog_img[s].x = 6'(prog_n);
              prog_img[s].y = 6'(s + 1);
            end
          end
        end
        default: begin
          // Two-way choice.
          s = emit(OP_SPLIT, 8'($urandom), 0, 0);
          gen_seq(depth - 1);
          j = emit(OP_JUMP, 8'($urandom), 0, 0);
          if (s >= 0) begin
            prog_img[s].x = 6'(s + 1);
            prog_img[s].y = 6'(prog_n);
          end
          gen_seq(depth - 1);
          if (j >= 0) prog_img[j].x = 6'(prog_n);
        end
      endcase
    end
  endfunction

  function automatic void build_program();
    int d;
    int k;
    prog_n = 0;
    if ($urandom_range(9) == 0) begin
      // More groups than the block reports.
      for (int i = 0; i < 10; i++) begin
        d = emit(OP_OPEN, 8'($urandom), 0, 0);
        d = emit(OP_ANY, 8'($urandom), 0, 0);
        d = emit(OP_CLOSE, 8'($urandom), 0, 0);
      end
    end else begin
      gen_seq(3);
    end
    prog_img[prog_n] = '{OP_MATCH, 8'($urandom), 6'($urandom), 6'($urandom)};
    prog_n++;
    // Now and then corrupt a word to break bracket balance or targets.
    if ($urandom_range(99) < 15) begin
      k = $urandom_range(prog_n - 1);
      prog_img[k] = '{3'($urandom), 8'($urandom), 6'($urandom), 6'($urandom)};
    end
  endfunction

  initial begin
    int tlen;
    start <= 1'b0;
    rst_n <= 1'b0;
    in_req_type <= '0;
    in_prog_addr <= '0;
    in_prog_op <= '0;
    in_prog_char <= '0;
    in_prog_x <= '0;
    in_prog_y <= '0;
    in_text_char <= '0;
    top_addr = -1;
    item_count = 0;
    session_count = 0;
    calm = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty program sessions, then a hand-built program with the edge cases.
    send_eot();
    send_char(8'h00);
    send_eot();
    prog_n = 9;
    prog_img[0] = '{OP_SPLIT, 8'h00, 6'd1, 6'd5};
    prog_img[1] = '{OP_OPEN, 8'h00, 6'd0, 6'd0};
    prog_img[2] = '{OP_CHAR, 8'h00, 6'd0, 6'd0};
    prog_img[3] = '{OP_CLOSE, 8'h00, 6'd0, 6'd0};
    prog_img[4] = '{OP_JUMP, 8'h00, 6'd63, 6'd63};
    prog_img[5] = '{OP_CHAR, 8'hFF, 6'd0, 6'd0};
    prog_img[6] = '{OP_SPLIT, 8'h00, 6'd7, 6'd8};
    prog_img[7] = '{3'd7, 8'hAA, 6'd0, 6'd0};
    prog_img[8] = '{OP_MATCH, 8'h00, 6'd0, 6'd0};
    load_program();
    send_char(8'hFF);
    send_eot();
    send_char(8'h00);
    send_eot();
    send(2'd3, 6'h3F, 3'h7, 8'hFF, 6'h3F, 6'h3F, 8'hFF);
    send_eot();

    // Random sessions over random programs.
    while (item_count < 460) begin
      calm = (item_count > 200 && item_count < 290);
      if (session_count % 3 == 0 || $urandom_range(3) == 0) begin
        build_program();
        load_program();
      end
      tlen = $urandom_range(10);
      for (int i = 0; i < tlen; i++) begin
        case ($urandom_range(19))
          0: send(REQ_PROG, 6'($urandom_range(top_addr)), 3'($urandom), 8'($urandom),
                  6'($urandom), 6'($urandom), 8'($urandom));
          1: send(2'd3, 6'($urandom), 3'($urandom), 8'($urandom), 6'($urandom),
                  6'($urandom), 8'($urandom));
          default: send_char(pick_letter());
        endcase
      end
      send_eot();
    end

    // Short session over a split chain that overflows the closure stack.
    calm = 1;
    prog_n = 64;
    for (int i = 0; i < 64; i++) prog_img[i] = '{OP_SPLIT, 8'($urandom), 6'(i + 1), 6'd0};
    load_program();
    for (int i = 0; i < 4; i++) send_char(8'($urandom));
    send_eot();
    start <= 1'b0;

    while (pending_count != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("Ran %0d items in %0d text sessions, one overflowing the closure stack.",
             item_count, session_count);
    $display("Checked %0d group reports, %0d of them from matching sessions.",
             result_count, match_count);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: pike_vm_regex_matcher.f
+incdir+rtl
rtl/pvm_pkg.sv
rtl/pvm_pair.sv
rtl/pike_vm_regex_matcher.sv
bench/regex_capture_checker.sv
bench/pike_vm_regex_matcher_tb.sv
